// ===== design/uf2bwt_pkg.sv =====
`timescale 1ns / 1ps

package uf2bwt_pkg;

   // geometry of the written-block bitmap
   localparam int unsigned BLOCK_LIMIT_DEFAULT = 8192;
   localparam int unsigned ROW_BITS            = 8;
   localparam int unsigned ROW_SEL_BITS        = 3;

   // field widths
   localparam int unsigned WORD_W   = 32;
   localparam int unsigned LENGTH_W = 9;
   localparam int unsigned COUNT_W  = 14;

   // published header values
   localparam logic [WORD_W-1:0] MAGIC_START_FIRST  = 32'h0A32_4655;
   localparam logic [WORD_W-1:0] MAGIC_START_SECOND = 32'h9E5D_5157;
   localparam logic [WORD_W-1:0] MAGIC_FINAL        = 32'h0AB1_6F30;
   localparam int unsigned       FLAG_FAMILY_BIT    = 13;
   localparam int unsigned       FLAG_NO_FLASH_BIT  = 0;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 14'h3FFF;
   localparam logic [WORD_W-1:0]  ALL_ONES  = 32'hFFFF_FFFF;

   localparam logic STATUS_ACCEPTED = 1'b0;
   localparam logic STATUS_REJECTED = 1'b1;

   typedef struct packed {
      logic [WORD_W-1:0]   magic_start_first;
      logic [WORD_W-1:0]   magic_start_second;
      logic [WORD_W-1:0]   magic_final;
      logic [WORD_W-1:0]   block_flags;
      logic [WORD_W-1:0]   block_family;
      logic [WORD_W-1:0]   block_number;
      logic [WORD_W-1:0]   total_blocks;
      logic [WORD_W-1:0]   target_address;
      logic [LENGTH_W-1:0] payload_length;
   } req_word_type;

   typedef struct packed {
      logic                status;
      logic                flash_write_request;
      logic [WORD_W-1:0]   flash_address;
      logic [LENGTH_W-1:0] flash_length;
      logic                flush_request;
      logic [COUNT_W-1:0]  written_so_far;
      logic [WORD_W-1:0]   expected_count;
   } rsp_word_type;

   // bitmap handshake between the tracker and the map store
   typedef struct packed {
      logic lookup_en;
      logic update_en;
   } map_ctrl_type;

endpackage

// ===== design/uf2bwt_req_if.sv =====
`timescale 1ns / 1ps

interface uf2bwt_req_if;
   logic                       valid;
   logic                       ready;
   uf2bwt_pkg::req_word_type   payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== design/uf2bwt_rsp_if.sv =====
`timescale 1ns / 1ps

interface uf2bwt_rsp_if;
   logic                       valid;
   logic                       ready;
   uf2bwt_pkg::rsp_word_type   payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== design/uf2bwt_map.sv =====
`timescale 1ns / 1ps

module uf2bwt_map #(
   parameter int unsigned BLOCK_LIMIT = uf2bwt_pkg::BLOCK_LIMIT_DEFAULT,
   localparam int unsigned MAP_ROWS  =
      (BLOCK_LIMIT + uf2bwt_pkg::ROW_BITS - 1) / uf2bwt_pkg::ROW_BITS,
   localparam int unsigned MAP_ROW_W = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1
) (
   input  logic                                clock,
   input  logic                                reset,
   input  uf2bwt_pkg::map_ctrl_type            ctrl,
   input  logic [MAP_ROW_W-1:0]                lookup_row,
   input  logic [MAP_ROW_W-1:0]                update_row,
   input  logic [uf2bwt_pkg::ROW_BITS-1:0]     update_data,
   output logic [uf2bwt_pkg::ROW_BITS-1:0]     row_data,
   output logic                                busy
);

   logic [uf2bwt_pkg::ROW_BITS-1:0] map_mem [MAP_ROWS];

   logic                            clear_busy_ff;
   logic [MAP_ROW_W-1:0]            clear_row_ff;
   logic [uf2bwt_pkg::ROW_BITS-1:0] rd_data_ff;
   logic                            fwd_hit_ff;
   logic [uf2bwt_pkg::ROW_BITS-1:0] fwd_data_ff;

   logic                            mem_we;
   logic [MAP_ROW_W-1:0]            mem_wr_row;
   logic [uf2bwt_pkg::ROW_BITS-1:0] mem_wr_data;

   always_comb begin
      mem_we      = clear_busy_ff || ctrl.update_en;
      mem_wr_row  = clear_busy_ff ? clear_row_ff : update_row;
      mem_wr_data = clear_busy_ff ? '0 : update_data;
   end

   // clearing sweep after reset, one row per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_busy_ff <= 1'b1;
         clear_row_ff  <= '0;
      end else if (clear_busy_ff) begin
         if (clear_row_ff == MAP_ROW_W'(MAP_ROWS - 1)) begin
            clear_busy_ff <= 1'b0;
         end else begin
            clear_row_ff <= clear_row_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[mem_wr_row] <= mem_wr_data;
      end
      if (ctrl.lookup_en) begin
         rd_data_ff  <= map_mem[lookup_row];
         fwd_data_ff <= update_data;
      end
   end

   // a write at the same edge as the read is missed by the memory read, so it is forwarded
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_hit_ff <= 1'b0;
      end else if (ctrl.lookup_en) begin
         fwd_hit_ff <= ctrl.update_en && (update_row == lookup_row);
      end
   end

   assign row_data = fwd_hit_ff ? fwd_data_ff : rd_data_ff;
   assign busy     = clear_busy_ff;

endmodule

// ===== design/uf2_block_write_tracker_unit.sv =====
`timescale 1ns / 1ps

// channel   dir  handshake      word
// req_chan  in   valid/ready    one block header (magics, flags, family, number, total, ...)
// rsp_chan  out  valid/ready    status, flash write command, flush, count, expected total
// csr       in   write enable   accepted family, 32 bits
//
// one word accepted per cycle unless the result stalls
// stage one holds the header and the bitmap row read at acceptance; the
// compare, bitmap update and count work sit between it and the result register
// after reset the bitmap is swept clear, ceil(BLOCK_LIMIT/8) rows
// (1024 at the default), while req_chan.ready stays low
// a stalled result holds stage one; stage one still takes a word as it drains

module uf2_block_write_tracker_unit #(
   parameter int unsigned BLOCK_LIMIT = uf2bwt_pkg::BLOCK_LIMIT_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [uf2bwt_pkg::WORD_W-1:0]   csr_write_data,
   uf2bwt_req_if.sink                      req_chan,
   uf2bwt_rsp_if.source                    rsp_chan
);

   localparam int unsigned MAP_ROWS  =
      (BLOCK_LIMIT + uf2bwt_pkg::ROW_BITS - 1) / uf2bwt_pkg::ROW_BITS;
   localparam int unsigned MAP_ROW_W = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;
   localparam logic [uf2bwt_pkg::WORD_W-1:0] LIMIT_WORD =
      uf2bwt_pkg::WORD_W'(BLOCK_LIMIT);

   // configuration
   logic [uf2bwt_pkg::WORD_W-1:0]  accepted_family_ff;

   // tracking state
   logic [uf2bwt_pkg::WORD_W-1:0]  expected_total_ff;
   logic [uf2bwt_pkg::WORD_W-1:0]  expected_total_in;
   logic [uf2bwt_pkg::COUNT_W-1:0] written_total_ff;
   logic [uf2bwt_pkg::COUNT_W-1:0] written_total_in;

   // stage one and result register
   logic                           s1_valid_ff;
   uf2bwt_pkg::req_word_type       s1_word_ff;
   logic                           rsp_valid_ff;
   uf2bwt_pkg::rsp_word_type       rsp_word_ff;
   uf2bwt_pkg::rsp_word_type       rsp_word_in;

   logic                           req_fire;
   logic                           s1_fire;
   logic                           map_busy;
   uf2bwt_pkg::map_ctrl_type       map_ctrl;
   logic [uf2bwt_pkg::ROW_BITS-1:0] row_data;
   logic [uf2bwt_pkg::ROW_BITS-1:0] row_update;

   logic                           header_ok;
   logic                           block_ok;
   logic                           tracked;
   logic                           in_range;
   logic                           new_block;
   logic [uf2bwt_pkg::ROW_SEL_BITS-1:0] bit_sel;

   // handshake
   assign s1_fire        = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !map_busy && (!s1_valid_ff || s1_fire);
   assign req_fire       = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         accepted_family_ff <= '0;
      end else if (csr_write_enable) begin
         accepted_family_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_fire) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_fire) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_word_ff <= req_chan.payload;
      end
   end

   // header checks and bitmap decision for the word in stage one
   always_comb begin
      header_ok =
         (s1_word_ff.magic_start_first == uf2bwt_pkg::MAGIC_START_FIRST) &&
         (s1_word_ff.magic_start_second == uf2bwt_pkg::MAGIC_START_SECOND) &&
         (s1_word_ff.magic_final == uf2bwt_pkg::MAGIC_FINAL) &&
         s1_word_ff.block_flags[uf2bwt_pkg::FLAG_FAMILY_BIT] &&
         !s1_word_ff.block_flags[uf2bwt_pkg::FLAG_NO_FLASH_BIT];
      block_ok  = header_ok && (s1_word_ff.block_family == accepted_family_ff);
      tracked   = block_ok && (s1_word_ff.total_blocks != '0);
      in_range  = s1_word_ff.block_number < LIMIT_WORD;
      bit_sel   = s1_word_ff.block_number[uf2bwt_pkg::ROW_SEL_BITS-1:0];
      new_block = tracked && in_range && !row_data[bit_sel];
      row_update = row_data | (uf2bwt_pkg::ROW_BITS'(1) << bit_sel);

      // latch the total; conflicting or oversize totals poison it
      expected_total_in = expected_total_ff;
      if (tracked && (expected_total_ff != s1_word_ff.total_blocks)) begin
         if ((s1_word_ff.total_blocks >= LIMIT_WORD) || (expected_total_ff != '0)) begin
            expected_total_in = uf2bwt_pkg::ALL_ONES;
         end else begin
            expected_total_in = s1_word_ff.total_blocks;
         end
      end

      // saturating count of distinct blocks
      written_total_in = written_total_ff;
      if (new_block && (written_total_ff != uf2bwt_pkg::COUNT_MAX)) begin
         written_total_in = written_total_ff + 1'b1;
      end

      rsp_word_in.status              = block_ok ? uf2bwt_pkg::STATUS_ACCEPTED
                                                 : uf2bwt_pkg::STATUS_REJECTED;
      rsp_word_in.flash_write_request = block_ok;
      rsp_word_in.flash_address       = block_ok ? s1_word_ff.target_address : '0;
      rsp_word_in.flash_length        = block_ok ? s1_word_ff.payload_length : '0;
      rsp_word_in.flush_request       = tracked && in_range &&
         ({{(uf2bwt_pkg::WORD_W - uf2bwt_pkg::COUNT_W){1'b0}}, written_total_in}
          >= expected_total_in);
      rsp_word_in.written_so_far      = written_total_in;
      rsp_word_in.expected_count      = expected_total_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_total_ff <= '0;
         written_total_ff  <= '0;
      end else if (s1_fire) begin
         expected_total_ff <= expected_total_in;
         written_total_ff  <= written_total_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_word_ff;

   // bitmap store: read at acceptance, written back as stage one retires
   assign map_ctrl.lookup_en = req_fire;
   assign map_ctrl.update_en = s1_fire && new_block;

   uf2bwt_map #(
      .BLOCK_LIMIT (BLOCK_LIMIT)
   ) u_map (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (map_ctrl),
      .lookup_row  (req_chan.payload.block_number[uf2bwt_pkg::ROW_SEL_BITS +: MAP_ROW_W]),
      .update_row  (s1_word_ff.block_number[uf2bwt_pkg::ROW_SEL_BITS +: MAP_ROW_W]),
      .update_data (row_update),
      .row_data    (row_data),
      .busy        (map_busy)
   );

`ifndef NO_ASSERTIONS
   // no header taken while the bitmap sweep runs
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      map_busy |-> !req_chan.ready)
      else $error("header accepted during bitmap clear");

   // a flush only comes with a flash write command
   a_flush_needs_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_word_ff.flush_request |-> rsp_word_ff.flash_write_request)
      else $error("flush request on a block that is not written");

   // the distinct-block count only grows
   a_count_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> written_total_ff >= $past(written_total_ff))
      else $error("written block count went down");
`endif

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

   localparam int unsigned RANDOM_PER_PHASE = 170;
   localparam int unsigned LONG_HOLD_CYCLES = 80;
   localparam int unsigned TRACKED_TOTAL    = 150;
   localparam int unsigned NUMBER_SPAN      = 199;
   localparam logic [uf2bwt_pkg::WORD_W-1:0] FAMILY_FLAG  =
      uf2bwt_pkg::WORD_W'(1) << uf2bwt_pkg::FLAG_FAMILY_BIT;
   localparam logic [uf2bwt_pkg::WORD_W-1:0] NOFLASH_FLAG =
      uf2bwt_pkg::WORD_W'(1) << uf2bwt_pkg::FLAG_NO_FLASH_BIT;

   // tracks accepted headers and holds the replies the unit owes, oldest first
   class flash_write_predictor;
      logic [uf2bwt_pkg::WORD_W-1:0]  family_reg;
      logic [uf2bwt_pkg::WORD_W-1:0]  latched_total;
      logic [uf2bwt_pkg::COUNT_W-1:0] blocks_written;
      bit                             block_seen [uf2bwt_pkg::BLOCK_LIMIT_DEFAULT];
      uf2bwt_pkg::rsp_word_type       owed_replies [$];
      int unsigned                    mismatches, headers, rejects, flushes;

      function new();
         family_reg     = '0;
         latched_total  = '0;
         blocks_written = '0;
         mismatches     = 0;
         headers        = 0;
         rejects        = 0;
         flushes        = 0;
      endfunction

      function int unsigned pending();
         return owed_replies.size();
      endfunction

      function void take_header(uf2bwt_pkg::req_word_type h);
         uf2bwt_pkg::rsp_word_type r;
         logic                     ok;
         r  = '0;
         ok = h.magic_start_first == uf2bwt_pkg::MAGIC_START_FIRST &&
              h.magic_start_second == uf2bwt_pkg::MAGIC_START_SECOND &&
              h.magic_final == uf2bwt_pkg::MAGIC_FINAL &&
              h.block_flags[uf2bwt_pkg::FLAG_FAMILY_BIT] &&
              !h.block_flags[uf2bwt_pkg::FLAG_NO_FLASH_BIT] &&
              h.block_family == family_reg;
         headers++;
         if (!ok) begin
            r.status = uf2bwt_pkg::STATUS_REJECTED;
            rejects++;
         end else begin
            r.status              = uf2bwt_pkg::STATUS_ACCEPTED;
            r.flash_write_request = 1'b1;
            r.flash_address       = h.target_address;
            r.flash_length        = h.payload_length;
            if (h.total_blocks != '0) begin
               // a second differing total or an oversize one poisons the latch
               if (latched_total != h.total_blocks) begin
                  if (h.total_blocks >= uf2bwt_pkg::BLOCK_LIMIT_DEFAULT ||
                      latched_total != '0)
                     latched_total = uf2bwt_pkg::ALL_ONES;
                  else
                     latched_total = h.total_blocks;
               end
               if (h.block_number < uf2bwt_pkg::BLOCK_LIMIT_DEFAULT) begin
                  if (!block_seen[h.block_number]) begin
                     block_seen[h.block_number] = 1'b1;
                     if (blocks_written != uf2bwt_pkg::COUNT_MAX)
                        blocks_written++;
                  end
                  r.flush_request =
                     uf2bwt_pkg::WORD_W'(blocks_written) >= latched_total;
               end
            end
            if (r.flush_request)
               flushes++;
         end
         r.written_so_far = blocks_written;
         r.expected_count = latched_total;
         owed_replies.push_back(r);
      endfunction

      function void compare_field(string field, logic [uf2bwt_pkg::WORD_W-1:0] want,
                                  logic [uf2bwt_pkg::WORD_W-1:0] got);
         if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            mismatches++;
         end
      endfunction

      function void check_reply(uf2bwt_pkg::rsp_word_type got);
         uf2bwt_pkg::rsp_word_type want;
         if (owed_replies.size() == 0) begin
            $error("reply word with no header waiting: 0x%0h", got);
            mismatches++;
            return;
         end
         want = owed_replies.pop_front();
         compare_field("status", want.status, got.status);
         compare_field("flash_write_request", want.flash_write_request,
                       got.flash_write_request);
         compare_field("flash_address", want.flash_address, got.flash_address);
         compare_field("flash_length", want.flash_length, got.flash_length);
         compare_field("flush_request", want.flush_request, got.flush_request);
         compare_field("written_so_far", want.written_so_far, got.written_so_far);
         compare_field("expected_count", want.expected_count, got.expected_count);
      endfunction
   endclass

   logic                          clock;
   logic                          reset;
   logic                          csr_write_enable;
   logic [uf2bwt_pkg::WORD_W-1:0] csr_write_data;

   uf2bwt_req_if req_bus ();
   uf2bwt_rsp_if rsp_bus ();

   flash_write_predictor tracker = new();

   logic [uf2bwt_pkg::WORD_W-1:0] active_family;
   bit                            gaps_on       = 1'b1;
   bit                            stalls_on     = 1'b1;
   bit                            long_hold_req = 1'b0;

   uf2_block_write_tracker_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_chan         (req_bus),
      .rsp_chan         (rsp_bus)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // both channels observed at the rising edge, before the unit updates
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            tracker.take_header(req_bus.payload);
         if (rsp_bus.valid && rsp_bus.ready)
            tracker.check_reply(rsp_bus.payload);
      end
   end

   // result side: random stall bursts, plus one long hold-off on request
   initial begin : reply_sink
      int unsigned hold_left;
      bit          long_hold_done;
      hold_left      = 0;
      long_hold_done = 1'b0;
      rsp_bus.ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left != 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (long_hold_req && !long_hold_done) begin
            long_hold_done = 1'b1;
            hold_left      = LONG_HOLD_CYCLES - 1;
            rsp_bus.ready <= 1'b0;
         end else if (stalls_on && $urandom_range(0, 5) == 0) begin
            hold_left     = $urandom_range(0, 12);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // offer one header word; returns at the falling edge after acceptance
   task automatic send_header(input uf2bwt_pkg::req_word_type h);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.payload <= h;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // sender pause until every owed reply is back, then a short settle
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (tracker.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_family(input logic [uf2bwt_pkg::WORD_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable     <= 1'b0;
      active_family        = value;
      tracker.family_reg   = value;
   endtask

   // header with the published magics, family flag set, current family
   function automatic uf2bwt_pkg::req_word_type good_header(
      input logic [uf2bwt_pkg::WORD_W-1:0]   number,
      input logic [uf2bwt_pkg::WORD_W-1:0]   total,
      input logic [uf2bwt_pkg::WORD_W-1:0]   address,
      input logic [uf2bwt_pkg::LENGTH_W-1:0] length);
      uf2bwt_pkg::req_word_type h;
      h.magic_start_first  = uf2bwt_pkg::MAGIC_START_FIRST;
      h.magic_start_second = uf2bwt_pkg::MAGIC_START_SECOND;
      h.magic_final        = uf2bwt_pkg::MAGIC_FINAL;
      h.block_flags        = FAMILY_FLAG;
      h.block_family       = active_family;
      h.block_number       = number;
      h.total_blocks       = total;
      h.target_address     = address;
      h.payload_length     = length;
      return h;
   endfunction

   // mostly block numbers within the tracked span, occasionally the map edges or any 32-bit value
   function automatic uf2bwt_pkg::req_word_type random_header(input bit well_formed);
      uf2bwt_pkg::req_word_type        h;
      int unsigned                     pick;
      logic [uf2bwt_pkg::WORD_W-1:0]   number;
      logic [uf2bwt_pkg::LENGTH_W-1:0] length;
      pick = $urandom_range(0, 19);
      if (pick < 16)
         number = $urandom_range(0, NUMBER_SPAN);
      else if (pick == 16)
         number = uf2bwt_pkg::BLOCK_LIMIT_DEFAULT - 1;
      else if (pick == 17)
         number = uf2bwt_pkg::BLOCK_LIMIT_DEFAULT;
      else
         number = $urandom();
      if ($urandom_range(0, 9) == 0)
         length = uf2bwt_pkg::LENGTH_W'($urandom_range(477, 511));
      else
         length = uf2bwt_pkg::LENGTH_W'($urandom_range(0, 476));
      h = good_header(number, ($urandom_range(0, 5) == 0) ? '0 : TRACKED_TOTAL,
                      $urandom(), length);
      h.block_flags = ($urandom() | FAMILY_FLAG) & ~NOFLASH_FLAG;
      if (!well_formed) begin
         // each corruption alone is enough to reject the block
         h.block_number = $urandom();
         h.total_blocks = $urandom();
         case ($urandom_range(0, 5))
            0: h.magic_start_first  ^= $urandom() | 32'h1;
            1: h.magic_start_second ^= $urandom() | 32'h1;
            2: h.magic_final        ^= $urandom() | 32'h1;
            3: h.block_flags        &= ~FAMILY_FLAG;
            4: h.block_flags        |= NOFLASH_FLAG;
            default: h.block_family ^= $urandom() | 32'h1;
         endcase
      end
      return h;
   endfunction

   initial begin : header_source
      uf2bwt_pkg::req_word_type      h;
      logic [uf2bwt_pkg::WORD_W-1:0] phase_family [4];
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      req_bus.valid    = 1'b0;
      req_bus.payload  = '0;
      active_family    = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      write_family(32'hE48B_FF56);

      // zero total: written, nothing tracked
      send_header(good_header(0, 0, 32'hFFFF_FFFF, 476));
      send_header(good_header(5, 0, 32'h0, 0));
      // each rejection cause in turn
      h = good_header(0, TRACKED_TOTAL, 32'h1234_5678, 511);
      h.magic_start_first = ~uf2bwt_pkg::MAGIC_START_FIRST;
      send_header(h);
      h = good_header(0, TRACKED_TOTAL, 32'h1234_5678, 12);
      h.magic_start_second = 32'h0;
      send_header(h);
      h = good_header(0, TRACKED_TOTAL, 32'h1234_5678, 12);
      h.magic_final = 32'hFFFF_FFFF;
      send_header(h);
      h = good_header(0, TRACKED_TOTAL, 32'h1234_5678, 12);
      h.block_flags = '0;
      send_header(h);
      h = good_header(0, TRACKED_TOTAL, 32'h1234_5678, 12);
      h.block_flags = FAMILY_FLAG | NOFLASH_FLAG;
      send_header(h);
      h = good_header(0, TRACKED_TOTAL, 32'h1234_5678, 12);
      h.block_family = active_family ^ 32'h1;
      send_header(h);
      // first nonzero total latches, all other flag bits set
      h = good_header(0, TRACKED_TOTAL, 32'h1000_0000, 256);
      h.block_flags = ~NOFLASH_FLAG;
      send_header(h);
      send_header(good_header(1, TRACKED_TOTAL, 32'h1000_0100, 256));
      // repeated block does not count
      send_header(good_header(1, TRACKED_TOTAL, 32'h1000_0100, 256));
      // last tracked number, then just past the map, then the top value
      send_header(good_header(uf2bwt_pkg::BLOCK_LIMIT_DEFAULT - 1, TRACKED_TOTAL,
                              32'h2000_0000, 1));
      send_header(good_header(uf2bwt_pkg::BLOCK_LIMIT_DEFAULT, TRACKED_TOTAL,
                              32'h2000_0100, 2));
      send_header(good_header(32'hFFFF_FFFF, TRACKED_TOTAL, 32'h2000_0200, 3));
      // oversize length goes through unchanged
      send_header(good_header(2, TRACKED_TOTAL, 32'h3000_0000, 511));
      send_header(good_header(3, 0, 32'h3000_0100, 476));
      wait_drained();

      // random phases under different family settings, extremes included;
      // the last phase runs with no idling on either side
      phase_family = '{$urandom(), 32'h0, 32'hFFFF_FFFF, $urandom()};
      for (int unsigned phase = 0; phase < 4; phase++) begin
         write_family(phase_family[phase]);
         if (phase == 3) begin
            gaps_on   = 1'b0;
            stalls_on = 1'b0;
         end
         for (int unsigned n = 0; n < RANDOM_PER_PHASE; n++) begin
            // long receiver hold-off while headers keep coming
            if (phase == 0 && n == 40)
               long_hold_req = 1'b1;
            send_header(random_header($urandom_range(0, 3) != 0));
         end
         wait_drained();
      end

      // inconsistent totals: oversize total poisons the latch for good
      send_header(good_header(7, uf2bwt_pkg::BLOCK_LIMIT_DEFAULT, 32'h4000_0000, 100));
      send_header(good_header(8, TRACKED_TOTAL, 32'h4000_0100, 100));
      send_header(good_header(9, 32'hFFFF_FFFF, 32'h4000_0200, 100));
      for (int unsigned n = 0; n < 12; n++) begin
         h = random_header($urandom_range(0, 3) != 0);
         h.total_blocks = $urandom();
         send_header(h);
      end
      wait_drained();
      repeat (10) @(negedge clock);

      $display("headers sent: %0d (%0d rejected), flush replies: %0d",
               tracker.headers, tracker.rejects, tracker.flushes);
      $display("distinct blocks tracked: %0d, final latched total 0x%0h",
               tracker.blocks_written, tracker.latched_total);
      if (tracker.mismatches == 0)
         $display("uf2_block_write_tracker_unit test passed");
      else
         $display("uf2_block_write_tracker_unit test failed");
      $finish;
   end

   // covers the bitmap sweep after reset and every burst and stall many times over
   initial begin : watchdog
      #3_000_000;
      $display("uf2_block_write_tracker_unit test failed");
      $finish;
   end

endmodule
